/* rtl/core/lphs_pkg.sv */
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared constants, types and helpers for the linear probing hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

   localparam int SLOT_COUNT = 52;
   localparam int KEY_BYTES  = 8;

   // port widths fixed by the channel definitions
   localparam int KEY_IN_W = 64;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;

   // stored key width and slot index width
   localparam int KEY_W = 8 * KEY_BYTES;
   localparam int IDX_W = $clog2(SLOT_COUNT);

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam int LOWER_BASE = 26;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_FIND   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FOUND      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_NOT_LETTER = 3'd5;

   // access to the slot store
   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [KEY_W-1:0] wr_key;
   } store_req_type;

   // registered read data, valid in the cycle after rd_addr
   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key;
   } store_rsp_type;

   // finished transaction handed to the output register
   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } result_type;

   function automatic logic is_letter(input logic [7:0] c);
      is_letter = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
                  ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
   endfunction

   function automatic logic [IDX_W-1:0] home_slot(input logic [7:0] c);
      logic [7:0] ofs;
      if (c <= CHAR_UPPER_Z) begin
         ofs = c - CHAR_UPPER_A;
         home_slot = IDX_W'(ofs);
      end else begin
         ofs = c - CHAR_LOWER_A;
         home_slot = IDX_W'(ofs) + IDX_W'(LOWER_BASE);
      end
   endfunction

endpackage

/* rtl/core/lphs_if.sv */
// ----------------------------------------------------------------------------
// lphs channel interfaces
// Valid/ready channels for requests and responses of the hash set.
// ----------------------------------------------------------------------------
interface lphs_req_if;
   import lphs_pkg::*;

   logic                valid;
   logic                ready;
   logic                mode;
   logic [KEY_IN_W-1:0] key;

   modport source (output valid, output mode, output key, input ready);
   modport sink (input valid, input mode, input key, output ready);
endinterface

interface lphs_rsp_if;
   import lphs_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink (input valid, input status, input slot, output ready);
endinterface

/* rtl/core/linear_probe_hash_set.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Set of short text keys, open addressing with linear probing.
// ----------------------------------------------------------------------------
//  channel   direction  payload            transaction
//  req_chan  in         mode, key          insert or find one key
//  rsp_chan  out        status, slot       one response per request
//
// A request is accepted, then probes slots one at a time (1 to 52, set by the
// single key compare and the one read port of the key memory), and then moves
// into the response register once that register is free.
// A key whose first character is not a letter finishes without probing.
// Reset empties every slot at once; stored keys need no clearing.
// While the response waits on rsp_chan, the next request is taken and probed.
// ----------------------------------------------------------------------------
module linear_probe_hash_set (
   input  logic      clock,
   input  logic      reset,
   lphs_req_if.sink  req_chan,
   lphs_rsp_if.source rsp_chan
);
   import lphs_pkg::*;

   store_req_type       store_req;
   store_rsp_type       store_rsp;
   result_type          result;
   logic                result_taken;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;

   lphs_probe_seq u_probe_seq (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .store_req    (store_req),
      .store_rsp    (store_rsp),
      .result       (result),
      .result_taken (result_taken)
   );

   lphs_slot_store u_slot_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .store_rsp (store_rsp)
   );

   // output register frees up as the current response is taken
   assign result_taken = result.valid && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_taken) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_taken) begin
         rsp_status_ff <= result.status;
         rsp_slot_ff   <= result.slot;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.slot   = rsp_slot_ff;

endmodule

/* rtl/core/lphs_slot_store.sv */
// ----------------------------------------------------------------------------
// lphs_slot_store
// Key memory with one write and one registered read port, plus used flags.
// ----------------------------------------------------------------------------
module lphs_slot_store (
   input  logic                    clock,
   input  logic                    reset,
   input  lphs_pkg::store_req_type store_req,
   output lphs_pkg::store_rsp_type store_rsp
);
   import lphs_pkg::*;

   logic [KEY_W-1:0]      key_mem_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] used_ff;
   logic [SLOT_COUNT-1:0] used_in;
   logic [KEY_W-1:0]      rd_key_ff;
   logic                  rd_used_ff;

   always_comb begin
      used_in = used_ff;
      if (store_req.wr_en) begin
         used_in[store_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         key_mem_ff[store_req.wr_addr] <= store_req.wr_key;
      end
      rd_key_ff <= key_mem_ff[store_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         rd_used_ff <= 1'b0;
      end else begin
         used_ff    <= used_in;
         rd_used_ff <= used_ff[store_req.rd_addr];
      end
   end

   assign store_rsp.used = rd_used_ff;
   assign store_rsp.key  = rd_key_ff;

endmodule

/* rtl/core/lphs_probe_seq.sv */
// ----------------------------------------------------------------------------
// lphs_probe_seq
// Probe sequencer: walks slots from the home slot, one compare per cycle.
// ----------------------------------------------------------------------------
module lphs_probe_seq (
   input  logic                    clock,
   input  logic                    reset,
   lphs_req_if.sink                req_chan,
   output lphs_pkg::store_req_type store_req,
   input  lphs_pkg::store_rsp_type store_rsp,
   output lphs_pkg::result_type    result,
   input  logic                    result_taken
);
   import lphs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_DONE
   } state_type;

   state_type           state_ff;
   logic                mode_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    count_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [SLOT_W-1:0]   slot_ff;

   logic [7:0]          first_char;
   logic [IDX_W-1:0]    home_idx;
   logic [IDX_W-1:0]    next_idx;
   logic                key_match;
   logic                last_probe;
   logic                accept;

   assign first_char = req_chan.key[7:0];
   assign home_idx   = home_slot(first_char);
   assign next_idx   = (idx_ff == IDX_W'(SLOT_COUNT - 1)) ? '0 : idx_ff + 1'b1;
   // stored key only counts when its slot is in use
   assign key_match  = store_rsp.used && (store_rsp.key == key_ff);
   assign last_probe = (count_ff == IDX_W'(SLOT_COUNT - 1));
   assign accept     = req_chan.valid && (state_ff == ST_IDLE);

   assign req_chan.ready = (state_ff == ST_IDLE);

   // read of the next slot is issued while the current one is checked
   always_comb begin
      store_req.rd_addr = (state_ff == ST_IDLE) ? home_idx : next_idx;
      store_req.wr_en   = (state_ff == ST_PROBE) && (mode_ff == MODE_INSERT) &&
                          !store_rsp.used;
      store_req.wr_addr = idx_ff;
      store_req.wr_key  = key_ff;
   end

   assign result.valid  = (state_ff == ST_DONE);
   assign result.status = status_ff;
   assign result.slot   = slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= STATUS_NOT_FOUND;
         slot_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  mode_ff  <= req_chan.mode;
                  key_ff   <= req_chan.key[KEY_W-1:0];
                  idx_ff   <= home_idx;
                  count_ff <= '0;
                  slot_ff  <= '0;
                  if (is_letter(first_char)) begin
                     state_ff <= ST_PROBE;
                  end else begin
                     status_ff <= STATUS_NOT_LETTER;
                     state_ff  <= ST_DONE;
                  end
               end
            end
            ST_PROBE: begin
               if (!store_rsp.used) begin
                  state_ff <= ST_DONE;
                  if (mode_ff == MODE_INSERT) begin
                     status_ff <= STATUS_INSERTED;
                     slot_ff   <= idx_ff[SLOT_W-1:0];
                  end else begin
                     status_ff <= STATUS_NOT_FOUND;
                  end
               end else if (key_match) begin
                  state_ff  <= ST_DONE;
                  slot_ff   <= idx_ff[SLOT_W-1:0];
                  status_ff <= (mode_ff == MODE_INSERT) ? STATUS_DUPLICATE : STATUS_FOUND;
               end else if (last_probe) begin
                  state_ff  <= ST_DONE;
                  status_ff <= (mode_ff == MODE_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
               end else begin
                  idx_ff   <= next_idx;
                  count_ff <= count_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (result_taken) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
